@@ rtl/wtsu_pkg.sv @@
// Shared constants, codes and types of the three-voice wavetable sound unit.
package wtsu_pkg;

   localparam int VOICES      = 3;
   localparam int VOICE_W     = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int NUM_REGS    = 32;
   localparam int REG_ADDR_W  = 5;
   localparam int WAVE_DEPTH  = 256;
   localparam int WAVE_ADDR_W = 8;
   localparam int PHASE_W     = 20;
   localparam int NIB_W       = 4;
   localparam int WSEL_W      = 3;
   localparam int PIDX_W      = 5;
   localparam int PROD_W      = 2 * NIB_W;
   localparam int SAMPLE_W    = 10;
   localparam int CSR_IDX_W   = 4;
   localparam int OUTQ_DEPTH  = 2;
   localparam int OUTQ_CNT_W  = $clog2(OUTQ_DEPTH + 1);
   localparam int OUTQ_PTR_W  = $clog2(OUTQ_DEPTH);
   localparam int SAMPLE_MAX  = 675;

   // sound register map, voice v uses base + VOICE_STRIDE * v
   localparam int VOICE_STRIDE  = 5;
   localparam int REG_WSEL_BASE = 'h05;
   localparam int REG_FREQ0_LO  = 'h10;
   localparam int REG_FREQ_BASE = 'h11;
   localparam int REG_VOL_BASE  = 'h15;

   localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);

   typedef enum logic [1:0] {
      MODE_TICK    = 2'd0,
      MODE_REG_WR  = 2'd1,
      MODE_WAVE_WR = 2'd2
   } mode_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MUTE   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_EN = CSR_IDX_W'(1);

   // one wave read in flight, as seen by the mixer
   typedef struct packed {
      logic             valid;
      logic             first;
      logic             last;
      logic             emit;
      logic [NIB_W-1:0] vol;
   } slot_type;

endpackage

@@ rtl/wtsu_mixer.sv @@
// Voice product accumulation, mute and the result queue with its credit count.
module wtsu_mixer import wtsu_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  slot_type            slot,
   input  logic [NIB_W-1:0]    rd_data,
   input  logic                mute,
   input  logic                claim,
   output logic                room,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [SAMPLE_W-1:0] rsp_sample
);

   logic [PROD_W-1:0]     prod;
   logic [SAMPLE_W-1:0]   acc_ff, acc_in;
   logic [SAMPLE_W-1:0]   q_ff [OUTQ_DEPTH];
   logic [OUTQ_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [OUTQ_CNT_W-1:0] count_ff, credit_ff;
   logic                  push, pop;

   assign prod   = PROD_W'(rd_data) * PROD_W'(slot.vol);
   assign acc_in = (slot.first ? '0 : acc_ff) + SAMPLE_W'(prod);
   assign push   = slot.valid && slot.last && slot.emit;
   assign pop    = rsp_valid && rsp_ready;

   assign rsp_valid  = (count_ff != '0);
   assign rsp_sample = q_ff[rd_ptr_ff];
   // results owed to the sink, counted from acceptance of the tick
   assign room       = (credit_ff < OUTQ_CNT_W'(OUTQ_DEPTH));

   always_ff @(posedge clock) begin
      if (slot.valid) begin
         acc_ff <= acc_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= mute ? '0 : acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         credit_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff  <= count_ff + OUTQ_CNT_W'(push) - OUTQ_CNT_W'(pop);
         credit_ff <= credit_ff + OUTQ_CNT_W'(claim) - OUTQ_CNT_W'(pop);
      end
   end

endmodule

@@ rtl/wavetable_three_voice_sound_unit.sv @@
// Top level of the three-voice wavetable sound unit.
//
// Each req_ item is a tick (mode 0), a sound register write (mode 1, address 0..31,
// higher addresses ignored) or a waveform store write (mode 2); mode 3 is taken and
// dropped. A tick reads its voices in turn, voice 0 on acceptance and the rest while
// busy, because all voices share the single read port of the 256 x 4 waveform memory:
// for each voice its phase is advanced and its wave nibble is read. The product of
// nibble and volume is summed in the cycle after the read, and with the last voice's
// sum the sample enters a two-deep result queue in the same cycle. With output
// enabled a tick yields one rsp_ item; req_ready stays low until the tick's last voice
// is read, and also drops while two results are owed to a stalled sink. Both ready
// outputs stay low while reset is held. The waveform memory has no reset and must be
// written before it is played.
// Configuration: csr_index 0 is mute (reset 1), 1 is output enable (reset 0);
// change them only while the unit is idle.
module wavetable_three_voice_sound_unit import wtsu_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_mode,
   input  logic [7:0]           req_address,
   input  logic [7:0]           req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SAMPLE_W-1:0]  rsp_sample,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_data
);

   // sound registers: flops, every field read at a fixed place
   logic [NIB_W-1:0]   sreg_ff  [NUM_REGS];
   logic [PHASE_W-1:0] phase_ff [VOICES];
   logic [NIB_W-1:0]   wave_mem [WAVE_DEPTH];
   logic [NIB_W-1:0]   wave_rd_ff;

   logic               busy_ff;
   logic [VOICE_W-1:0] voice_ff;
   logic               mute_ff, oe_ff;
   slot_type           slot_ff, slot_in;

   logic [PHASE_W-1:0] freq_v [VOICES];
   logic [NIB_W-1:0]   vol_v  [VOICES];
   logic [WSEL_W-1:0]  wsel_v [VOICES];

   logic                   req_acc, tick_acc, sreg_wr, wave_wr, issue, room, claim;
   logic [VOICE_W-1:0]     cur_v;
   logic [PHASE_W-1:0]     phase_new;
   logic [WAVE_ADDR_W-1:0] wave_addr;

   assign req_ready = !reset && !busy_ff && room;
   assign req_acc   = req_valid && req_ready;
   assign tick_acc  = req_acc && (req_mode == MODE_TICK);
   assign sreg_wr   = req_acc && (req_mode == MODE_REG_WR) && (req_address[7:REG_ADDR_W] == '0);
   assign wave_wr   = req_acc && (req_mode == MODE_WAVE_WR);
   assign claim     = tick_acc && oe_ff;
   assign csr_ready = !reset;

   // voice fields from the register map
   always_comb begin
      for (int v = 0; v < VOICES; v++) begin
         freq_v[v] = {sreg_ff[REG_ADDR_W'(REG_FREQ_BASE + 3 + VOICE_STRIDE * v)],
                      sreg_ff[REG_ADDR_W'(REG_FREQ_BASE + 2 + VOICE_STRIDE * v)],
                      sreg_ff[REG_ADDR_W'(REG_FREQ_BASE + 1 + VOICE_STRIDE * v)],
                      sreg_ff[REG_ADDR_W'(REG_FREQ_BASE + VOICE_STRIDE * v)],
                      (v == 0) ? sreg_ff[REG_ADDR_W'(REG_FREQ0_LO)] : {NIB_W{1'b0}}};
         vol_v[v]  = sreg_ff[REG_ADDR_W'(REG_VOL_BASE + VOICE_STRIDE * v)];
         wsel_v[v] = sreg_ff[REG_ADDR_W'(REG_WSEL_BASE + VOICE_STRIDE * v)][WSEL_W-1:0];
      end
   end

   // voice 0 goes on the acceptance cycle, the rest while busy
   assign issue     = tick_acc || busy_ff;
   assign cur_v     = busy_ff ? voice_ff : '0;
   assign phase_new = phase_ff[cur_v] + freq_v[cur_v];
   assign wave_addr = {wsel_v[cur_v], phase_new[PHASE_W-1 -: PIDX_W]};

   always_comb begin
      slot_in.valid = issue;
      slot_in.first = (cur_v == '0);
      slot_in.last  = (cur_v == LAST_VOICE);
      slot_in.emit  = oe_ff;
      slot_in.vol   = vol_v[cur_v];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         voice_ff <= '0;
         slot_ff  <= '0;
         mute_ff  <= 1'b1;
         oe_ff    <= 1'b0;
         for (int r = 0; r < NUM_REGS; r++) begin
            sreg_ff[r] <= '0;
         end
         for (int v = 0; v < VOICES; v++) begin
            phase_ff[v] <= '0;
         end
      end else begin
         slot_ff <= slot_in;
         if (issue) begin
            phase_ff[cur_v] <= phase_new;
         end
         if (tick_acc) begin
            busy_ff  <= (VOICES > 1);
            voice_ff <= VOICE_W'(1);
         end else if (busy_ff) begin
            if (voice_ff == LAST_VOICE) begin
               busy_ff <= 1'b0;
            end else begin
               voice_ff <= voice_ff + 1'b1;
            end
         end
         if (sreg_wr) begin
            sreg_ff[req_address[REG_ADDR_W-1:0]] <= req_data[NIB_W-1:0];
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MUTE:   mute_ff <= csr_data;
               CSR_OUT_EN: oe_ff   <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // waveform memory: one write, one registered read; a later write never
   // overtakes a read already issued
   always_ff @(posedge clock) begin
      if (wave_wr) begin
         wave_mem[req_address] <= req_data[NIB_W-1:0];
      end
      if (issue) begin
         wave_rd_ff <= wave_mem[wave_addr];
      end
   end

   wtsu_mixer u_mixer (
      .clock      (clock),
      .reset      (reset),
      .slot       (slot_ff),
      .rd_data    (wave_rd_ff),
      .mute       (mute_ff),
      .claim      (claim),
      .room       (room),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );

endmodule

@@ rtl/wtsu_checker.sv @@
// Port-level checks of the sound unit, bound to the top level.
module wtsu_checker import wtsu_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic [1:0]          req_mode,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_sample
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled result changed");

   // three products of at most 15 x 15
   a_rsp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_sample <= SAMPLE_W'(SAMPLE_MAX))
      else $error("sample out of range");

   // a tick holds the wave read port for the following voices
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_mode == MODE_TICK |=> !req_ready)
      else $error("item accepted while voices still being read");

   // reset empties the result queue
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result present after reset");

endmodule

bind wavetable_three_voice_sound_unit wtsu_checker u_wtsu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_valid),
   .req_ready  (req_ready),
   .req_mode   (req_mode),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_sample (rsp_sample)
);

@@ sim/testbench.sv @@
// Self-checking testbench of the three-voice wavetable sound unit.
`timescale 1ns / 100ps

module testbench;
   import wtsu_pkg::*;

   localparam logic [1:0]           MODE_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE   = CSR_IDX_W'(15);
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 170;
   // per random phase: mute and output enable; phase 2 runs with no idling at all
   localparam logic [PHASES-1:0] PLAN_MUTE   = 6'b100010;
   localparam logic [PHASES-1:0] PLAN_OUT_EN = 6'b010111;

   // Scoreboard: own copy of the sound state, predicts the sample of each tick
   class sample_board;
      logic [NIB_W-1:0]    sound_reg [NUM_REGS];
      logic [PHASE_W-1:0]  phase [VOICES];
      logic [NIB_W-1:0]    wave [WAVE_DEPTH];
      bit                  mute;
      bit                  out_en;
      logic [SAMPLE_W-1:0] pending_samples [$];
      int                  failures;
      int                  checked;
      int                  ticks;
      int                  reg_writes;
      int                  wave_writes;

      function new();
         foreach (sound_reg[i]) sound_reg[i] = '0;
         foreach (phase[i]) phase[i] = '0;
         foreach (wave[i]) wave[i] = '0;
         mute   = 1'b1;
         out_en = 1'b0;
      endfunction

      function void set_control(logic [CSR_IDX_W-1:0] index, logic value);
         case (index)
            CSR_MUTE: begin
               mute = value;
            end
            CSR_OUT_EN: begin
               out_en = value;
            end
            default: begin
            end
         endcase
      endfunction

      // one tick: advance every phase, read one nibble per voice, scale and sum
      function logic [SAMPLE_W-1:0] mix_tick();
         logic [PHASE_W-1:0]     step;
         logic [WAVE_ADDR_W-1:0] waddr;
         int unsigned            sum;
         int                     b;
         sum = 0;
         for (int v = 0; v < VOICES; v++) begin
            b = VOICE_STRIDE * v;
            step = {sound_reg[REG_FREQ_BASE + b + 3], sound_reg[REG_FREQ_BASE + b + 2],
                    sound_reg[REG_FREQ_BASE + b + 1], sound_reg[REG_FREQ_BASE + b],
                    (v == 0) ? sound_reg[REG_FREQ0_LO] : 4'h0};
            phase[v] = phase[v] + step;
            waddr = {sound_reg[REG_WSEL_BASE + b][WSEL_W-1:0],
                     phase[v][PHASE_W-1 -: PIDX_W]};
            sum += int'(wave[waddr]) * int'(sound_reg[REG_VOL_BASE + b]);
         end
         return mute ? '0 : SAMPLE_W'(sum);
      endfunction

      function void note_item(logic [1:0] mode, logic [7:0] address, logic [7:0] data);
         logic [SAMPLE_W-1:0] s;
         case (mode)
            MODE_TICK: begin
               ticks++;
               s = mix_tick();
               if (out_en) pending_samples.push_back(s);
            end
            MODE_REG_WR: begin
               reg_writes++;
               if (address < NUM_REGS) sound_reg[address] = data[NIB_W-1:0];
            end
            MODE_WAVE_WR: begin
               wave_writes++;
               wave[address] = data[NIB_W-1:0];
            end
            default: begin
            end
         endcase
      endfunction

      function void check_sample(logic [SAMPLE_W-1:0] got);
         logic [SAMPLE_W-1:0] want;
         checked++;
         if (pending_samples.size() == 0) begin
            $error("sample: none expected, actual %0d", got);
            failures++;
         end else begin
            want = pending_samples.pop_front();
            if (got !== want) begin
               $error("sample: expected %0d, actual %0d", want, got);
               failures++;
            end
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_mode = MODE_TICK;
   logic [7:0]           req_address = '0;
   logic [7:0]           req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [SAMPLE_W-1:0]  rsp_sample;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic                 csr_data = 1'b0;

   bit          steady = 1'b0;   // when set neither side idles
   int          cycles = 0;
   sample_board board = new();

   wavetable_three_voice_sound_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_mode    (req_mode),
      .req_address (req_address),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_sample  (rsp_sample),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Result side: sample the handshake as it stood before this edge, then pick
   // the next cycle's ready, stalling with a chance of 31 in a hundred unless steady.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_sample(rsp_sample);
      rsp_ready <= steady || ($urandom_range(99) >= 31);
   end

   // Offer one item and hold it until taken. Valid is never dropped after an
   // accept here: the next call either opens a gap or presents the next item
   // in the same step, so valid only ever gets one assignment per edge.
   task automatic send_item(input logic [1:0] mode, input logic [7:0] address,
                            input logic [7:0] data);
      while (!steady && $urandom_range(99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= mode;
      req_address <= address;
      req_data    <= data;
      do @(posedge clock); while (!req_ready);
      board.note_item(mode, address, data);
   endtask

   // Stop sending, let every owed sample come back, then let the voice pipe
   // run dry (ticks with output off leave no trace in the queue).
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (board.pending_samples.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index, input logic value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_control(index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int          r;
      logic [7:0]  a;
      logic [1:0]  m;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The wave memory has no reset, so load all of it before the first tick;
      // afterwards every read hits a written entry.
      for (int i = 0; i < WAVE_DEPTH; i++) send_item(MODE_WAVE_WR, 8'(i), 8'($urandom));

      // --- directed ---
      // reset config: muted, output off -> tick advances nothing visible
      send_item(MODE_TICK, 8'h00, 8'h00);
      wait_idle();
      write_csr(CSR_SPARE, 1'b1);          // undefined index, must be ignored
      write_csr(CSR_OUT_EN, 1'b1);
      send_item(MODE_TICK, 8'hFF, 8'hFF);  // muted -> sample 0
      wait_idle();
      write_csr(CSR_MUTE, 1'b0);

      // full volume, waveform 7 on every voice; phases and freqs still zero,
      // so every voice reads entry 224 -> largest sample
      for (int v = 0; v < VOICES; v++)
         send_item(MODE_REG_WR, 8'(REG_VOL_BASE + VOICE_STRIDE * v), 8'hFF);
      for (int v = 0; v < VOICES; v++)
         send_item(MODE_REG_WR, 8'(REG_WSEL_BASE + VOICE_STRIDE * v), 8'hFF);
      send_item(MODE_WAVE_WR, {3'd7, 5'd0}, 8'hFF);
      send_item(MODE_TICK, 8'h00, 8'h00);

      // voice 0 to waveform 0 (nibble 8, select bits 0) on a zero entry
      send_item(MODE_REG_WR, 8'(REG_WSEL_BASE), 8'hF8);
      send_item(MODE_WAVE_WR, 8'h00, 8'hF0);
      send_item(MODE_TICK, 8'h00, 8'h00);

      // writes above the register file alias real registers if wrapped;
      // the unused mode would clear voice 0 volume if taken as a write
      send_item(MODE_REG_WR, 8'(NUM_REGS + REG_WSEL_BASE), 8'hF7);
      send_item(MODE_REG_WR, 8'hFF, 8'h00);
      send_item(MODE_UNUSED, 8'(REG_VOL_BASE), 8'h00);
      send_item(MODE_TICK, 8'h00, 8'h00);

      // top frequency on voice 0 and the top nibble on the last voice
      for (int k = 0; k < 5; k++) send_item(MODE_REG_WR, 8'(REG_FREQ0_LO + k), 8'hFF);
      send_item(MODE_REG_WR, 8'(REG_FREQ_BASE + VOICE_STRIDE * (VOICES - 1) + 3), 8'hFF);
      send_item(MODE_TICK, 8'h00, 8'h00);
      send_item(MODE_TICK, 8'h00, 8'h00);

      // --- random phases, each under its own mute / output setting ---
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         write_csr(CSR_MUTE, PLAN_MUTE[p]);
         write_csr(CSR_OUT_EN, PLAN_OUT_EN[p]);
         steady = (p == 2);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            r = $urandom_range(99);
            a = 8'($urandom);
            if (r < 45) begin
               m = MODE_TICK;
            end else if (r < 75) begin
               // mostly live registers, now and then an address past the end
               m = MODE_REG_WR;
               a = ($urandom_range(9) == 0) ? 8'($urandom_range(255, NUM_REGS))
                                            : 8'($urandom_range(NUM_REGS - 1));
            end else if (r < 95) begin
               m = MODE_WAVE_WR;
            end else begin
               m = MODE_UNUSED;
            end
            send_item(m, a, 8'($urandom));
         end
      end
      steady = 1'b0;
      wait_idle();

      if (board.pending_samples.size() != 0)
         $error("sample: %0d expected, never arrived", board.pending_samples.size());
      $display("run: %0d ticks, %0d register and %0d wave writes over %0d settings",
               board.ticks, board.reg_writes, board.wave_writes, PHASES + 3);
      $display("run: %0d samples checked, %0d mismatches", board.checked, board.failures);
      if (board.failures == 0 && board.pending_samples.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
